// ----- rtl/core/idd_pkg.sv -----
// Shared widths and types for the invariant-divisor divide/modulo block.
package idd_pkg;

  localparam int unsigned DIVIDEND_W = 32;
  localparam int unsigned QUOTIENT_W = 32;
  localparam int unsigned DIVISOR_W  = 31;
  localparam int unsigned REM_W      = 31;
  localparam int unsigned SHIFT_W    = 5;

  // Derived shift settings handed from the reciprocal unit to the datapath.
  typedef struct packed {
    logic               pre;
    logic [SHIFT_W-1:0] post;
  } shift_cfg_t;

endpackage

// ----- rtl/core/idd_recip.sv -----
// Reciprocal derivation: multiplier and shifts computed after a divisor write.
module idd_recip #(
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  input  logic [idd_pkg::DIVISOR_W-1:0]      cfg_data_i,
  output logic                               cfg_ready_o,
  input  logic                               pipe_empty_i,
  output logic                               busy_o,
  output logic [idd_pkg::DIVISOR_W-1:0]      divisor_o,
  output logic [DATA_WIDTH-1:0]              mult_o,
  output idd_pkg::shift_cfg_t                shift_o
);

  localparam int unsigned CNT_W = $clog2(DATA_WIDTH);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DATA_WIDTH - 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_NORM = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;

  localparam logic [idd_pkg::DIVISOR_W-1:0] TOP_ONE = {1'b1, {(idd_pkg::DIVISOR_W-1){1'b0}}};
  localparam logic [idd_pkg::SHIFT_W-1:0]   LOG_MAX = idd_pkg::SHIFT_W'(idd_pkg::DIVISOR_W - 1);

  logic [1:0]                         state_q, state_d;
  logic [idd_pkg::DIVISOR_W-1:0]      divisor_q;
  logic [idd_pkg::DIVISOR_W-1:0]      norm_q;
  logic [idd_pkg::SHIFT_W-1:0]        log_q;
  logic                               pre_pend_q;
  logic [idd_pkg::DIVISOR_W-1:0]      rem_q;
  logic [DATA_WIDTH-1:0]              quo_q;
  logic [CNT_W-1:0]                   cnt_q;
  logic [DATA_WIDTH-1:0]              mult_q;
  idd_pkg::shift_cfg_t                shift_q;

  logic                               cfg_xfer;
  logic                               is_pow2;
  logic [idd_pkg::DIVISOR_W:0]        pow_next;
  logic [idd_pkg::DIVISOR_W:0]        rem_sh;
  logic                               rem_ge;
  logic [DATA_WIDTH-1:0]              quo_next;

  assign cfg_ready_o = (state_q == ST_IDLE) && pipe_empty_i;
  assign cfg_xfer    = cfg_valid_i && cfg_ready_o;
  // No dividend enters in the cycle of a divisor transfer.
  assign busy_o      = (state_q != ST_IDLE) || cfg_xfer;

  // Normalized divisor has only its top bit set for a power of two.
  assign is_pow2  = (norm_q == TOP_ONE);
  assign pow_next = (idd_pkg::DIVISOR_W + 1)'(2) << log_q;

  // One restoring step per cycle of 2^(pre+log) * 2^DW / d.
  assign rem_sh   = {rem_q, 1'b0};
  assign rem_ge   = (rem_sh >= {1'b0, divisor_q});
  assign quo_next = {quo_q[DATA_WIDTH-2:0], rem_ge};

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (cfg_xfer && (cfg_data_i != '0)) state_d = ST_NORM;
      end
      ST_NORM: begin
        if (norm_q[idd_pkg::DIVISOR_W-1]) state_d = ST_DIV;
      end
      ST_DIV: begin
        if (cnt_q == CNT_LAST) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      divisor_q <= idd_pkg::DIVISOR_W'(1);
      mult_q    <= DATA_WIDTH'(1);
      shift_q   <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_IDLE && cfg_xfer && (cfg_data_i != '0)) begin
        divisor_q <= cfg_data_i;
      end
      if (state_q == ST_DIV && cnt_q == CNT_LAST) begin
        mult_q       <= quo_next + DATA_WIDTH'(1);
        shift_q.pre  <= pre_pend_q;
        shift_q.post <= log_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        norm_q <= cfg_data_i;
        log_q  <= LOG_MAX;
      end
      ST_NORM: begin
        if (norm_q[idd_pkg::DIVISOR_W-1]) begin
          pre_pend_q <= !is_pow2;
          // Initial remainder: 2^(log+1) - d when not a power of two, else zero.
          rem_q      <= is_pow2 ? '0 : idd_pkg::DIVISOR_W'(pow_next - {1'b0, divisor_q});
          cnt_q      <= '0;
        end else begin
          norm_q <= {norm_q[idd_pkg::DIVISOR_W-2:0], 1'b0};
          log_q  <= log_q - idd_pkg::SHIFT_W'(1);
        end
      end
      ST_DIV: begin
        rem_q <= rem_ge ? idd_pkg::DIVISOR_W'(rem_sh - {1'b0, divisor_q})
                        : rem_sh[idd_pkg::DIVISOR_W-1:0];
        quo_q <= quo_next;
        cnt_q <= cnt_q + CNT_W'(1);
      end
      default: begin
        cnt_q <= '0;
      end
    endcase
  end

  assign divisor_o = divisor_q;
  assign mult_o    = mult_q;
  assign shift_o   = shift_q;

endmodule

// ----- rtl/core/invariant_divisor_divmod.sv -----
// Top level: pipelined unsigned divide/modulo by a programmable invariant divisor.
//
// Usage:
//   Divisor channel: divisor_i with divisor_valid_i / divisor_ready_o. A transfer
//   happens when both are high. Ready is high only while no derivation runs and
//   the pipeline holds no item. A zero divisor is taken and ignored.
//   After a nonzero write the reciprocal unit normalizes the divisor (one
//   left shift per leading zero), then runs DATA_WIDTH restoring steps, one
//   quotient bit a cycle. busy is high meanwhile and in the cycle of the
//   divisor transfer itself.
//   Dividend channel: dividend_i is taken on a rising edge with start high and
//   busy low. One dividend may enter every cycle while busy is low.
//   Results: quotient_o / remainder_o are shown for exactly one cycle with
//   done_o high, in input order. The receiver cannot stall, so the pipeline
//   never holds.
//   Pipeline: input register, high multiply, subtract/shift/add, post shift,
//   back multiply, final subtract. The two 32x32 multipliers set the stage depth.
//   Reset: divisor 1 with multiplier 1 and both shifts zero; pipeline empty.
module invariant_divisor_divmod #(
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  logic [idd_pkg::DIVIDEND_W-1:0]  dividend_i,
  input  logic                            divisor_valid_i,
  output logic                            divisor_ready_o,
  input  logic [idd_pkg::DIVISOR_W-1:0]   divisor_i,
  output logic                            done_o,
  output logic [idd_pkg::QUOTIENT_W-1:0]  quotient_o,
  output logic [idd_pkg::REM_W-1:0]       remainder_o
);

  localparam int unsigned DW = DATA_WIDTH;

  logic [idd_pkg::DIVISOR_W-1:0] divisor;
  logic [DW-1:0]                 mult;
  idd_pkg::shift_cfg_t           shift_cfg;
  logic                          pipe_empty;
  logic                          in_xfer;

  // Stage valids: 1 input, 2 high mul, 3 fixup, 4 post shift, 5 back mul, 6 out.
  logic [5:0] vld_q;

  logic [DW-1:0]   x1_q, x2_q, x3_q, x4_q, x5_q;
  logic [DW-1:0]   hi2_q, t3_q, q4_q, q5_q, qd5_q, q6_q, r6_q;
  logic [2*DW-1:0] prod_hi;
  logic [DW-1:0]   diff2;
  logic [DW-1:0]   div_trunc;

  idd_recip #(
    .DATA_WIDTH (DW)
  ) u_recip (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (divisor_valid_i),
    .cfg_data_i   (divisor_i),
    .cfg_ready_o  (divisor_ready_o),
    .pipe_empty_i (pipe_empty),
    .busy_o       (busy),
    .divisor_o    (divisor),
    .mult_o       (mult),
    .shift_o      (shift_cfg)
  );

  assign in_xfer    = start && !busy;
  assign pipe_empty = (vld_q == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[4:0], in_xfer};
    end
  end

  // Full product x * m; only its high half is registered.
  assign prod_hi   = {{DW{1'b0}}, x1_q} * {{DW{1'b0}}, mult};
  // (x - hi) wraps modulo 2^DW as in the scheme.
  assign diff2     = x2_q - hi2_q;
  // Back multiply only needs the low DW bits, so the divisor is zero-extended to DW bits.
  assign div_trunc = DW'(divisor);

  always_ff @(posedge clk_i) begin
    x1_q  <= dividend_i[DW-1:0];

    x2_q  <= x1_q;
    hi2_q <= prod_hi[2*DW-1:DW];

    x3_q  <= x2_q;
    t3_q  <= (diff2 >> shift_cfg.pre) + hi2_q;

    x4_q  <= x3_q;
    q4_q  <= t3_q >> shift_cfg.post;

    x5_q  <= x4_q;
    q5_q  <= q4_q;
    qd5_q <= q4_q * div_trunc;

    q6_q  <= q5_q;
    r6_q  <= x5_q - qd5_q;
  end

  assign done_o      = vld_q[5];
  assign quotient_o  = idd_pkg::QUOTIENT_W'(q6_q);
  assign remainder_o = idd_pkg::REM_W'(r6_q);

endmodule

// ----- tb/tb_invariant_divisor_divmod.sv -----
// Self-checking testbench for the invariant-divisor divide/modulo block.
`timescale 1ns / 1ps

module tb_invariant_divisor_divmod;

  localparam time CLK_HALF = 6ns;

  // One expected quotient/remainder pair per accepted dividend.
  typedef struct packed {
    logic [idd_pkg::QUOTIENT_W-1:0] quotient;
    logic [idd_pkg::REM_W-1:0]      remainder;
  } divmod_t;

  logic                           clk_i = 1'b0;
  logic                           rst_ni = 1'b0;
  logic                           start = 1'b0;
  logic                           busy;
  logic [idd_pkg::DIVIDEND_W-1:0] dividend_i = '0;
  logic                           divisor_valid_i = 1'b0;
  logic                           divisor_ready_o;
  logic [idd_pkg::DIVISOR_W-1:0]  divisor_i = '0;
  logic                           done_o;
  logic [idd_pkg::QUOTIENT_W-1:0] quotient_o;
  logic [idd_pkg::REM_W-1:0]      remainder_o;

  // Shadow of the divisor register and the reciprocal derived from it.
  // Reset values match divisor 1: multiplier 1, both shifts zero.
  logic [idd_pkg::DIVISOR_W-1:0]  model_divisor = 31'd1;
  logic [idd_pkg::DIVIDEND_W-1:0] model_mult = 32'd1;
  idd_pkg::shift_cfg_t            model_shift = '0;

  divmod_t pending_results[$];
  int unsigned error_count = 0;
  int unsigned results_checked = 0;
  int unsigned items_sent = 0;
  int unsigned divisor_writes = 0;

  invariant_divisor_divmod u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .dividend_i      (dividend_i),
    .divisor_valid_i (divisor_valid_i),
    .divisor_ready_o (divisor_ready_o),
    .divisor_i       (divisor_i),
    .done_o          (done_o),
    .quotient_o      (quotient_o),
    .remainder_o     (remainder_o)
  );

  always #(CLK_HALF) clk_i = ~clk_i;

  // Global watchdog: the slowest legal run is well under 1 ms of sim time.
  initial begin
    #5ms;
    $display("%t timeout with %0d results still pending", $time, pending_results.size());
    $display("[invariant_divisor_divmod] ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Recompute multiplier and shifts for a new divisor:
  //   post = floor(log2 d), pre = 0 only for powers of two,
  //   mult = floor(2^(32+pre+post) / d) + 1, kept to 32 bits.
  function automatic void derive_reciprocal(input logic [idd_pkg::DIVISOR_W-1:0] d);
    logic [idd_pkg::DIVISOR_W-1:0] v;
    logic [63:0]                   num;
    logic [63:0]                   m;
    int unsigned                   lg;
    logic                          pre;
    v   = d;
    lg  = 0;
    while (v > 1) begin
      v = v >> 1;
      lg++;
    end
    pre = ((d & (d - 31'd1)) != '0);
    num = 64'd1 << (idd_pkg::DIVIDEND_W + pre + lg);
    m   = num / {33'd0, d} + 64'd1;
    model_divisor    = d;
    model_mult       = m[idd_pkg::DIVIDEND_W-1:0];
    model_shift.pre  = pre;
    model_shift.post = lg[idd_pkg::SHIFT_W-1:0];
  endfunction

  // High multiply, subtract, pre shift, add, post shift; remainder by back multiply.
  function automatic divmod_t divide_by_reciprocal(
    input logic [idd_pkg::DIVIDEND_W-1:0] x
  );
    logic [63:0]                    prod;
    logic [idd_pkg::DIVIDEND_W-1:0] hi;
    logic [idd_pkg::DIVIDEND_W-1:0] t;
    logic [idd_pkg::DIVIDEND_W-1:0] q;
    logic [idd_pkg::DIVIDEND_W-1:0] r;
    divmod_t                        res;
    prod = {32'd0, x} * {32'd0, model_mult};
    hi   = prod[63:32];
    t    = x - hi;
    t    = t >> model_shift.pre;
    t    = t + hi;
    q    = t >> model_shift.post;
    r    = x - q * {1'b0, model_divisor};
    res.quotient  = q;
    res.remainder = r[idd_pkg::REM_W-1:0];
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Result checker: every done_o cycle must match the oldest expectation
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : check_results
    divmod_t want;
    if (done_o === 1'b1) begin
      if (pending_results.size() == 0) begin
        error_count++;
        $display("%t unexpected result: expected none, got q=%h r=%h",
                 $time, quotient_o, remainder_o);
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        if (quotient_o !== want.quotient) begin
          error_count++;
          $display("%t quotient mismatch: expected %h, actual %h",
                   $time, want.quotient, quotient_o);
        end
        if (remainder_o !== want.remainder) begin
          error_count++;
          $display("%t remainder mismatch: expected %h, actual %h",
                   $time, want.remainder, remainder_o);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers (inputs change on the falling edge)
  // ---------------------------------------------------------------------------

  // Present one dividend; start stays high afterwards so back-to-back
  // transfers need no toggle. The expectation is queued at the transfer edge.
  task automatic send_dividend(input logic [idd_pkg::DIVIDEND_W-1:0] x);
    @(negedge clk_i);
    start      <= 1'b1;
    dividend_i <= x;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    pending_results.insert(pending_results.size(), divide_by_reciprocal(x));
    items_sent++;
  endtask

  // Lower start before any edge can take the last dividend a second time.
  task automatic drop_start();
    @(negedge clk_i);
    start <= 1'b0;
  endtask

  // Sender gap with start low, its length set by n; the data bus carries junk meanwhile.
  task automatic hold_off_sender(input int unsigned n);
    drop_start();
    dividend_i <= $urandom;
    repeat (n - 1) @(negedge clk_i);
  endtask

  // Divisor writes only happen with the pipeline drained.
  task automatic write_divisor(input logic [idd_pkg::DIVISOR_W-1:0] d);
    drop_start();
    while (pending_results.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
    divisor_valid_i <= 1'b1;
    divisor_i       <= d;
    @(posedge clk_i);
    while (!divisor_ready_o) @(posedge clk_i);
    // zero is accepted by the channel but leaves the old setting in place
    if (d != '0) derive_reciprocal(d);
    divisor_writes++;
    @(negedge clk_i);
    divisor_valid_i <= 1'b0;
    divisor_i       <= idd_pkg::DIVISOR_W'($urandom);
  endtask

  // ---------------------------------------------------------------------------
  // Random value pickers
  // ---------------------------------------------------------------------------
  function automatic logic [idd_pkg::DIVISOR_W-1:0] pick_divisor(input int unsigned kind);
    logic [idd_pkg::DIVISOR_W-1:0] v;
    int unsigned                   k;
    case (kind % 6)
      0: v = idd_pkg::DIVISOR_W'($urandom_range(2, 16));
      1: begin
        k = $urandom_range(1, 30);
        v = 31'd1 << k;
      end
      2: begin
        // one off a power of two: worst case for the rounding of the multiplier
        k = $urandom_range(2, 30);
        v = (31'd1 << k);
        v = $urandom_range(0, 1) ? v + 31'd1 : v - 31'd1;
      end
      3: v = idd_pkg::DIVISOR_W'($urandom) | 31'h4000_0000;
      4: v = idd_pkg::DIVISOR_W'($urandom >> $urandom_range(1, 31));
      default: v = idd_pkg::DIVISOR_W'($urandom);
    endcase
    if (v == '0) v = 31'h7FFF_FFFF;
    return v;
  endfunction

  function automatic logic [idd_pkg::DIVIDEND_W-1:0] pick_dividend(
    input logic [idd_pkg::DIVISOR_W-1:0] d
  );
    logic [63:0] k;
    logic [63:0] v;
    case ($urandom_range(0, 5))
      0, 1: return $urandom;
      2: begin
        // land on, just below or just above a multiple of the divisor
        k = $urandom_range(0, 32'hFFFF_FFFF / {1'b0, d});
        v = k * {33'd0, d};
        return v[31:0] + 32'($urandom_range(0, 2)) - 32'd1;
      end
      3: return $urandom >> $urandom_range(0, 31);
      4: return $urandom_range(0, {d, 1'b0});
      default: begin
        case ($urandom_range(0, 3))
          0: return 32'h0000_0000;
          1: return 32'hFFFF_FFFF;
          2: return 32'h8000_0000;
          default: return 32'h7FFF_FFFF;
        endcase
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Out of reset the block must divide by one.
  task automatic test_reset_divisor();
    send_dividend(32'h0000_0000);
    send_dividend(32'hFFFF_FFFF);
    send_dividend(32'h0000_0001);
  endtask

  // Small odd divisor, largest divisor, largest power of two; dividends at
  // the edges of the range and right around the divisor.
  task automatic test_directed_extremes();
    write_divisor(31'd3);
    send_dividend(32'h0000_0000);
    send_dividend(32'h0000_0002);
    send_dividend(32'h0000_0003);
    send_dividend(32'hFFFF_FFFF);
    write_divisor(31'h7FFF_FFFF);
    send_dividend(32'h7FFF_FFFE);
    send_dividend(32'h7FFF_FFFF);
    send_dividend(32'hFFFF_FFFE);
    send_dividend(32'hFFFF_FFFF);
    write_divisor(31'h4000_0000);
    send_dividend(32'h3FFF_FFFF);
    send_dividend(32'h4000_0000);
    send_dividend(32'hFFFF_FFFF);
  endtask

  // A zero divisor is taken by the channel but must not change anything.
  task automatic test_zero_divisor_ignored();
    write_divisor('0);
    send_dividend(32'hAAAA_AAAA);
    send_dividend(32'h5555_5555);
    send_dividend(32'h8000_0000);
  endtask

  // Several divisor settings, bursty traffic; every fourth phase runs with
  // no sender gaps at all to keep the pipeline full.
  task automatic test_random_phases(input int unsigned total);
    int unsigned per_phase;
    int unsigned burst;
    bit          steady;
    per_phase = total / 10;
    for (int unsigned p = 0; p < 10; p++) begin
      if ($urandom_range(0, 3) == 0) write_divisor('0);
      if (p == 0)      write_divisor(31'd1);
      else if (p == 9) write_divisor(31'h7FFF_FFFF);
      else             write_divisor(pick_divisor(p));
      steady = (p % 4 == 3);
      burst  = $urandom_range(1, 40);
      for (int unsigned i = 0; i < per_phase; i++) begin
        send_dividend(pick_dividend(model_divisor));
        if (!steady) begin
          burst--;
          if (burst == 0) begin
            hold_off_sender($urandom_range(0, 3) == 0 ? $urandom_range(9, 30)
                                                      : $urandom_range(1, 8));
            burst = $urandom_range(1, 40);
          end
        end
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  initial begin
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_divisor();
    test_directed_extremes();
    test_zero_divisor_ignored();
    test_random_phases(1230);

    drop_start();
    while (pending_results.size() != 0) @(posedge clk_i);
    // pipeline is 6 deep: anything beyond that would be a stray result
    repeat (12) @(posedge clk_i);

    $display("Sent %0d dividends, checked %0d quotient/remainder pairs",
             items_sent, results_checked);
    $display("Divisor register written %0d times (zero, one, max, powers of two)",
             divisor_writes);
    if (error_count == 0) begin
      $display("[invariant_divisor_divmod] OK");
    end else begin
      $display("[invariant_divisor_divmod] ERROR");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/idd_pkg.sv
rtl/core/idd_recip.sv
rtl/core/invariant_divisor_divmod.sv
tb/tb_invariant_divisor_divmod.sv
